[hdl/veb_pkg.sv]
// ----------------------------------------------------------------------------
// veb_pkg
// Shared types and constants for the volume / balance front-panel tick block.
// ----------------------------------------------------------------------------
package veb_pkg;

   // Default number of channel buttons
   localparam int VEB_CHANNELS     = 4;
   localparam int VEB_MAX_CHANNELS = 8;
   localparam int VEB_LEVELS_W     = 4;

   // Field widths
   localparam int VEB_VOL_W    = 8;
   localparam int VEB_DELAY_W  = 16;
   localparam int VEB_SUM_W    = 18;
   localparam int VEB_SAMPLE_W = 10;
   localparam int VEB_BAL_W    = 6;
   localparam int VEB_CMD_W    = 3;
   // Command value before truncation: up to 2 + VEB_MAX_CHANNELS - 1
   localparam int VEB_CMD_CALC_W = 4;

   // CSR port
   localparam int VEB_ADDR_W = 4;
   localparam int VEB_DATA_W = 32;

   // Register reset values
   localparam logic [VEB_VOL_W-1:0]   VEB_VOLUME_MAX_RST = 8'd95;
   localparam logic [VEB_DELAY_W-1:0] VEB_SAVE_DELAY_RST = 16'd8000;
   localparam logic [VEB_SUM_W-1:0]   VEB_THRESHOLD_RST  = 18'd1024;

   // Debounce shift register reset value for the encoder lines
   localparam logic [7:0] VEB_ENC_SHIFT_RST = 8'h01;

   // Button command codes
   localparam logic [VEB_CMD_CALC_W-1:0] VEB_CMD_NONE  = 4'd0;
   localparam logic [VEB_CMD_CALC_W-1:0] VEB_CMD_POWER = 4'd1;
   localparam logic [VEB_CMD_CALC_W-1:0] VEB_CMD_CHAN0 = 4'd2;

   // Register index within the CSR map
   typedef enum logic [1:0] {
      VEB_REG_VOLUME_MAX = 2'd0,
      VEB_REG_SAVE_DELAY = 2'd1,
      VEB_REG_THRESHOLD  = 2'd2
   } veb_reg_type;

   // Status from the balance unit for the current item
   typedef struct packed {
      logic                        changed;
      logic signed [VEB_BAL_W-1:0] balance;
   } veb_bal_status_type;

endpackage

[hdl/veb_balance.sv]
// ----------------------------------------------------------------------------
// veb_balance
// Leaky sum of balance samples, threshold tracking and balance recompute.
// ----------------------------------------------------------------------------
module veb_balance import veb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [VEB_SAMPLE_W-1:0] sample,
   input  logic [VEB_SUM_W-1:0]    threshold,
   output veb_bal_status_type      status
);

   // 2731 / 65536 approximates 1/24 exactly for magnitudes up to 512
   localparam logic [11:0] RECIP_24 = 12'd2731;

   logic [VEB_SUM_W-1:0]        leaky_ff, leaky_in;
   logic [VEB_SUM_W-1:0]        taken_ff, taken_in;
   logic signed [VEB_BAL_W-1:0] balance_ff, balance_in;

   logic [VEB_SUM_W-1:0] diff;
   logic                 over;
   logic [10:0]          centered;
   logic                 neg;
   logic [9:0]           mag;
   logic [21:0]          prod;
   logic [VEB_BAL_W-1:0] quot;
   logic [VEB_BAL_W-1:0] new_balance;

   always_comb begin
      leaky_in = leaky_ff - {8'd0, leaky_ff[VEB_SUM_W-1:8]}
               + {{(VEB_SUM_W-VEB_SAMPLE_W){1'b0}}, sample};
      diff = (leaky_in >= taken_ff) ? (leaky_in - taken_ff) : (taken_ff - leaky_in);
      over = diff > threshold;

      // (sum >> 8) - 512, divided by 24 toward zero
      centered    = {1'b0, leaky_in[VEB_SUM_W-1:8]} - 11'd512;
      neg         = centered[10];
      mag         = neg ? 10'(-centered) : centered[9:0];
      prod        = mag * RECIP_24;
      quot        = {1'b0, prod[20:16]};
      new_balance = neg ? (-quot) : quot;

      taken_in   = over ? leaky_in : taken_ff;
      balance_in = over ? $signed(new_balance) : balance_ff;

      status.changed = over;
      status.balance = balance_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaky_ff   <= '0;
         taken_ff   <= '0;
         balance_ff <= '0;
      end else if (enable) begin
         leaky_ff   <= leaky_in;
         taken_ff   <= taken_in;
         balance_ff <= balance_in;
      end
   end

endmodule

[hdl/volume_encoder_balance_tick.sv]
// ----------------------------------------------------------------------------
// volume_encoder_balance_tick
// Front-panel tick: debounced encoder volume, leaky balance, save timer,
// button debounce and command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | contents
//  req_    | in        | valid / stall   | encoder lines, ADC sample, buttons
//  rsp_    | out       | valid / stall   | volume, balance, flags, command
//  csr     | in / out  | psel / penable  | volume_max, save_delay, threshold
//
//  One item per clock. Each accepted item updates all state in the same
//  cycle; its result appears in the output register on the next cycle.
//  Throughput is set by the single update stage: one item every cycle.
//  Synchronous reset clears the state (encoder shifts load 8'h01) but not
//  the result data; registers return to their defaults. A stalled result
//  holds and blocks input only while the output register is full.
// ----------------------------------------------------------------------------
module volume_encoder_balance_tick import veb_pkg::*; #(
   parameter int CHANNELS = VEB_CHANNELS
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_enc_a,
   input  logic                    req_enc_b,
   input  logic [VEB_SAMPLE_W-1:0] req_balance_sample,
   input  logic [VEB_LEVELS_W-1:0] req_button_levels,
   input  logic                    req_power_pin,
   input  logic                    req_clear_pending,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [VEB_VOL_W-1:0]    rsp_volume_position,
   output logic signed [VEB_BAL_W-1:0] rsp_balance_half_db,
   output logic                    rsp_update_pending,
   output logic                    rsp_save_strobe,
   output logic                    rsp_power_released,
   output logic [VEB_CMD_W-1:0]    rsp_button_command,

   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [VEB_ADDR_W-1:0]   paddr,
   input  logic [VEB_DATA_W-1:0]   pwdata,
   output logic [VEB_DATA_W-1:0]   prdata,
   output logic                    pready
);

   // Configuration registers
   logic [VEB_VOL_W-1:0]   volume_max_ff;
   logic [VEB_DELAY_W-1:0] save_delay_ff;
   logic [VEB_SUM_W-1:0]   threshold_ff;
   veb_reg_type            reg_sel;
   logic                   csr_write;

   // State
   logic [7:0]             shift_a_ff, shift_a_in;
   logic [7:0]             shift_b_ff, shift_b_in;
   logic [1:0]             gray_ff, gray_in;
   logic [3:0]             tick_ff, tick_in;
   logic [VEB_VOL_W-1:0]   volume_ff, volume_in;
   logic                   pending_ff, pending_in;
   logic [VEB_DELAY_W-1:0] countdown_ff, countdown_in;
   logic [7:0]             power_shift_ff, power_shift_in;
   logic [7:0]             button_shift_ff [CHANNELS];
   logic [7:0]             button_shift_in [CHANNELS];

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VEB_VOL_W-1:0]        rsp_volume_ff;
   logic signed [VEB_BAL_W-1:0] rsp_balance_ff;
   logic                        rsp_pending_ff;
   logic                        rsp_strobe_ff, strobe;
   logic                        rsp_released_ff;
   logic [VEB_CMD_W-1:0]        rsp_cmd_ff;

   logic                        accept;
   logic                        prev_settled, now_stable, enc_event;
   logic [1:0]                  ns;
   logic                        step_up, step_dn, vol_change, change;
   logic [VEB_DELAY_W-1:0]      cd_load;
   logic [VEB_MAX_CHANNELS-1:0] levels_ext;
   logic [VEB_CMD_CALC_W-1:0]   cmd;
   veb_bal_status_type          bal_status;

   // ---------------------------------------------------------------- CSR
   assign pready    = 1'b1;
   assign reg_sel   = veb_reg_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_max_ff <= VEB_VOLUME_MAX_RST;
         save_delay_ff <= VEB_SAVE_DELAY_RST;
         threshold_ff  <= VEB_THRESHOLD_RST;
      end else if (csr_write) begin
         unique case (reg_sel)
            VEB_REG_VOLUME_MAX: volume_max_ff <= pwdata[VEB_VOL_W-1:0];
            VEB_REG_SAVE_DELAY: save_delay_ff <= pwdata[VEB_DELAY_W-1:0];
            VEB_REG_THRESHOLD:  threshold_ff  <= pwdata[VEB_SUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         VEB_REG_VOLUME_MAX: prdata = {{(VEB_DATA_W-VEB_VOL_W){1'b0}}, volume_max_ff};
         VEB_REG_SAVE_DELAY: prdata = {{(VEB_DATA_W-VEB_DELAY_W){1'b0}}, save_delay_ff};
         VEB_REG_THRESHOLD:  prdata = {{(VEB_DATA_W-VEB_SUM_W){1'b0}}, threshold_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // ------------------------------------------------------------ balance
   veb_balance u_balance (
      .clock     (clock),
      .reset     (reset),
      .enable    (accept),
      .sample    (req_balance_sample),
      .threshold (threshold_ff),
      .status    (bal_status)
   );

   // ------------------------------------------------ encoder and volume
   always_comb begin
      prev_settled = (shift_a_ff == 8'h00 || shift_a_ff == 8'hff)
                  && (shift_b_ff == 8'h00 || shift_b_ff == 8'hff);
      shift_a_in = {shift_a_ff[6:0], req_enc_a};
      shift_b_in = {shift_b_ff[6:0], req_enc_b};
      now_stable = (shift_a_in == 8'h00 || shift_a_in == 8'hff)
                && (shift_b_in == 8'h00 || shift_b_in == 8'hff);
      enc_event  = ~prev_settled & now_stable;

      // Gray decode: B high reflects the A bit into states 2 and 3
      ns      = (|shift_b_in) ? (2'd3 - {1'b0, shift_a_in[0]}) : {1'b0, shift_a_in[0]};
      step_up = enc_event && (ns == gray_ff + 2'd1);
      step_dn = enc_event && (ns == gray_ff - 2'd1);
      gray_in = enc_event ? ns : gray_ff;

      volume_in  = volume_ff;
      vol_change = 1'b0;
      if (step_up && volume_ff < volume_max_ff) begin
         volume_in  = volume_ff + 8'd1;
         vol_change = 1'b1;
      end else if (step_dn && volume_ff != '0) begin
         volume_in  = volume_ff - 8'd1;
         vol_change = 1'b1;
      end
   end

   // ---------------------------------------------- pending and save timer
   always_comb begin
      change     = vol_change | bal_status.changed;
      pending_in = change | (pending_ff & ~req_clear_pending);
      cd_load    = change ? save_delay_ff : countdown_ff;
      if (cd_load != '0) begin
         countdown_in = cd_load - 16'd1;
         strobe       = (cd_load == 16'd1);
      end else begin
         countdown_in = cd_load;
         strobe       = 1'b0;
      end
   end

   // ------------------------------------------------------------ buttons
   assign levels_ext = {{(VEB_MAX_CHANNELS-VEB_LEVELS_W){1'b0}}, req_button_levels};
   assign tick_in    = tick_ff + 4'd1;

   always_comb begin
      power_shift_in = power_shift_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         button_shift_in[i] = button_shift_ff[i];
      end
      // buttons sample once every 16 ticks
      if (tick_in == 4'd0) begin
         power_shift_in = {power_shift_ff[6:0], ~req_power_pin};
         for (int i = 0; i < CHANNELS; i++) begin
            button_shift_in[i] = {button_shift_ff[i][6:0], levels_ext[i]};
         end
      end

      cmd = VEB_CMD_NONE;
      if (power_shift_in == 8'hff) begin
         cmd = VEB_CMD_POWER;
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (button_shift_in[i] == 8'hff) begin
               cmd = VEB_CMD_CHAN0 + VEB_CMD_CALC_W'(i);
            end
         end
      end
   end

   // ------------------------------------------------------------ state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_a_ff     <= VEB_ENC_SHIFT_RST;
         shift_b_ff     <= VEB_ENC_SHIFT_RST;
         gray_ff        <= '0;
         tick_ff        <= '0;
         volume_ff      <= '0;
         pending_ff     <= 1'b0;
         countdown_ff   <= '0;
         power_shift_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            button_shift_ff[i] <= '0;
         end
      end else if (accept) begin
         shift_a_ff     <= shift_a_in;
         shift_b_ff     <= shift_b_in;
         gray_ff        <= gray_in;
         tick_ff        <= tick_in;
         volume_ff      <= volume_in;
         pending_ff     <= pending_in;
         countdown_ff   <= countdown_in;
         power_shift_ff <= power_shift_in;
         for (int i = 0; i < CHANNELS; i++) begin
            button_shift_ff[i] <= button_shift_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_volume_ff   <= volume_in;
         rsp_balance_ff  <= bal_status.balance;
         rsp_pending_ff  <= pending_in;
         rsp_strobe_ff   <= strobe;
         rsp_released_ff <= (power_shift_in == 8'h00);
         rsp_cmd_ff      <= cmd[VEB_CMD_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_volume_position = rsp_volume_ff;
   assign rsp_balance_half_db = rsp_balance_ff;
   assign rsp_update_pending  = rsp_pending_ff;
   assign rsp_save_strobe     = rsp_strobe_ff;
   assign rsp_power_released  = rsp_released_ff;
   assign rsp_button_command  = rsp_cmd_ff;

endmodule

[hdl/veb_checker.sv]
// ----------------------------------------------------------------------------
// veb_checker
// Port-level checks for the volume / balance tick block.
// ----------------------------------------------------------------------------
module veb_checker import veb_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [VEB_BAL_W-1:0] rsp_balance_half_db,
   input logic                        rsp_power_released,
   input logic [VEB_CMD_W-1:0]        rsp_button_command
);

   // input blocks only while a result sits stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // every accepted item shows a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_balance_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_balance_half_db >= -6'sd21 && rsp_balance_half_db <= 6'sd21))
      else $error("balance out of range");

   // power command needs all ones, released needs all zeros
   a_power_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_button_command == VEB_CMD_POWER[VEB_CMD_W-1:0])
         |-> !rsp_power_released)
      else $error("power command while released");

endmodule

bind volume_encoder_balance_tick veb_checker u_veb_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_balance_half_db (rsp_balance_half_db),
   .rsp_power_released  (rsp_power_released),
   .rsp_button_command  (rsp_button_command)
);

[bench/volume_encoder_balance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_encoder_balance_checker
// Watches the tick and result channels and the register port of the
// front-panel block, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module volume_encoder_balance_checker import veb_pkg::*; #(
   parameter int CHANNELS = VEB_CHANNELS
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_enc_a,
   input  logic                        req_enc_b,
   input  logic [VEB_SAMPLE_W-1:0]     req_balance_sample,
   input  logic [VEB_LEVELS_W-1:0]     req_button_levels,
   input  logic                        req_power_pin,
   input  logic                        req_clear_pending,

   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [VEB_VOL_W-1:0]        rsp_volume_position,
   input  logic signed [VEB_BAL_W-1:0] rsp_balance_half_db,
   input  logic                        rsp_update_pending,
   input  logic                        rsp_save_strobe,
   input  logic                        rsp_power_released,
   input  logic [VEB_CMD_W-1:0]        rsp_button_command,

   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [VEB_ADDR_W-1:0]       paddr,
   input  logic [VEB_DATA_W-1:0]       pwdata,
   input  logic                        pready,

   output int                          fail_count,
   output int                          pending_results,
   output int                          results_checked,
   output int                          strobes_seen
);

   typedef struct packed {
      logic [VEB_VOL_W-1:0]        volume;
      logic signed [VEB_BAL_W-1:0] balance;
      logic                        pending;
      logic                        strobe;
      logic                        released;
      logic [VEB_CMD_W-1:0]        command;
   } panel_result_type;

   // register copies
   logic [VEB_VOL_W-1:0]   cfg_vol_max;
   logic [VEB_DELAY_W-1:0] cfg_save_delay;
   logic [VEB_SUM_W-1:0]   cfg_threshold;

   // predicted block state
   logic [7:0]              enc_hist_a, enc_hist_b;
   logic [1:0]              gray_pos;
   logic [3:0]              tick_phase;
   logic [VEB_VOL_W-1:0]    vol_pos;
   logic [VEB_SUM_W-1:0]    leak_acc, taken_acc;
   logic signed [VEB_BAL_W-1:0] bal_value;
   logic                    chg_pending;
   logic [VEB_DELAY_W-1:0]  save_count;
   logic [7:0]              pwr_hist;
   logic [7:0]              btn_hist [CHANNELS];

   panel_result_type expected_panel_q [$];

   function automatic logic settled(input logic [7:0] hist);
      return hist == 8'h00 || hist == 8'hff;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40)
         $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic touch_change();
      chg_pending = 1'b1;
      save_count  = cfg_save_delay;
   endtask

   task automatic predict_tick(input logic ea, input logic eb,
                               input logic [VEB_SAMPLE_W-1:0] smp,
                               input logic [VEB_LEVELS_W-1:0] lvl,
                               input logic pwr, input logic clr,
                               output panel_result_type r);
      logic                    was_settled;
      logic [1:0]              decoded;
      logic [VEB_SUM_W-1:0]    sum_gap;
      int                      bal;
      logic [VEB_CMD_CALC_W-1:0] cmd;
      logic                    strobe;
      strobe = 1'b0;
      cmd    = VEB_CMD_NONE;
      if (clr)
         chg_pending = 1'b0;
      tick_phase = tick_phase + 4'd1;

      // decode only on the tick both lines settle after bouncing
      was_settled = settled(enc_hist_a) && settled(enc_hist_b);
      enc_hist_a  = {enc_hist_a[6:0], ea};
      enc_hist_b  = {enc_hist_b[6:0], eb};
      if (!was_settled && settled(enc_hist_a) && settled(enc_hist_b)) begin
         decoded = enc_hist_b[0] ? 2'd3 - {1'b0, enc_hist_a[0]} : {1'b0, enc_hist_a[0]};
         if (decoded == gray_pos + 2'd1) begin
            if (vol_pos < cfg_vol_max) begin
               vol_pos = vol_pos + 1'b1;
               touch_change();
            end
         end else if (decoded == gray_pos - 2'd1) begin
            if (vol_pos != '0) begin
               vol_pos = vol_pos - 1'b1;
               touch_change();
            end
         end
         gray_pos = decoded;
      end

      if (tick_phase == 4'd0) begin
         pwr_hist = {pwr_hist[6:0], ~pwr};
         for (int i = 0; i < CHANNELS; i++)
            btn_hist[i] = {btn_hist[i][6:0], (i < VEB_LEVELS_W) ? lvl[i] : 1'b0};
      end

      leak_acc = leak_acc - (leak_acc >> 8) + VEB_SUM_W'(smp);
      sum_gap = (leak_acc >= taken_acc) ? leak_acc - taken_acc : taken_acc - leak_acc;
      if (sum_gap > cfg_threshold) begin
         taken_acc = leak_acc;
         bal       = (int'(taken_acc >> 8) - 512) / 24;
         bal_value = bal[VEB_BAL_W-1:0];
         touch_change();
      end

      if (save_count != '0) begin
         save_count = save_count - 1'b1;
         if (save_count == '0)
            strobe = 1'b1;
      end

      if (pwr_hist == 8'hff) begin
         cmd = VEB_CMD_POWER;
      end else begin
         for (int i = 0; i < CHANNELS; i++)
            if (btn_hist[i] == 8'hff)
               cmd = VEB_CMD_CHAN0 + VEB_CMD_CALC_W'(i);
      end

      r.volume   = vol_pos;
      r.balance  = bal_value;
      r.pending  = chg_pending;
      r.strobe   = strobe;
      r.released = (pwr_hist == 8'h00);
      r.command  = cmd[VEB_CMD_W-1:0];
   endtask

   always @(posedge clock) begin
      panel_result_type want;
      panel_result_type got;
      panel_result_type next_result;
      if (reset) begin
         cfg_vol_max    = VEB_VOLUME_MAX_RST;
         cfg_save_delay = VEB_SAVE_DELAY_RST;
         cfg_threshold  = VEB_THRESHOLD_RST;
         enc_hist_a     = VEB_ENC_SHIFT_RST;
         enc_hist_b     = VEB_ENC_SHIFT_RST;
         gray_pos       = '0;
         tick_phase     = '0;
         vol_pos        = '0;
         leak_acc       = '0;
         taken_acc      = '0;
         bal_value      = '0;
         chg_pending    = 1'b0;
         save_count     = '0;
         pwr_hist       = '0;
         for (int i = 0; i < CHANNELS; i++)
            btn_hist[i] = '0;
         expected_panel_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.volume   = rsp_volume_position;
            got.balance  = rsp_balance_half_db;
            got.pending  = rsp_update_pending;
            got.strobe   = rsp_save_strobe;
            got.released = rsp_power_released;
            got.command  = rsp_button_command;
            if (expected_panel_q.size() == 0) begin
               report_mismatch($sformatf("result with none expected (volume %0d)",
                                         got.volume));
            end else begin
               want = expected_panel_q.pop_front();
               results_checked++;
               if (want.strobe)
                  strobes_seen++;
               if (got.volume !== want.volume)
                  report_mismatch($sformatf("volume_position got %0d, expected %0d",
                                            got.volume, want.volume));
               if (got.balance !== want.balance)
                  report_mismatch($sformatf("balance_half_db got %0d, expected %0d",
                                            int'(got.balance), int'(want.balance)));
               if (got.pending !== want.pending)
                  report_mismatch($sformatf("update_pending got %b, expected %b",
                                            got.pending, want.pending));
               if (got.strobe !== want.strobe)
                  report_mismatch($sformatf("save_strobe got %b, expected %b",
                                            got.strobe, want.strobe));
               if (got.released !== want.released)
                  report_mismatch($sformatf("power_released got %b, expected %b",
                                            got.released, want.released));
               if (got.command !== want.command)
                  report_mismatch($sformatf("button_command got %0d, expected %0d",
                                            got.command, want.command));
            end
         end

         if (req_valid && !req_stall) begin
            predict_tick(req_enc_a, req_enc_b, req_balance_sample, req_button_levels,
                         req_power_pin, req_clear_pending, next_result);
            expected_panel_q.push_back(next_result);
         end

         if (psel && penable && pwrite && pready) begin
            case (veb_reg_type'(paddr[3:2]))
               VEB_REG_VOLUME_MAX: cfg_vol_max    = pwdata[VEB_VOL_W-1:0];
               VEB_REG_SAVE_DELAY: cfg_save_delay = pwdata[VEB_DELAY_W-1:0];
               VEB_REG_THRESHOLD:  cfg_threshold  = pwdata[VEB_SUM_W-1:0];
               default: ;
            endcase
         end
      end
      pending_results = expected_panel_q.size();
   end

endmodule

[bench/tb_volume_encoder_balance_tick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_encoder_balance_tick
// Drives encoder, balance ADC and button ticks into the front-panel block
// under random idle gaps and result stalls, across several register
// settings; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_volume_encoder_balance_tick;
   import veb_pkg::*;

   localparam int CLK_HALF       = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_enc_a = 1'b0;
   logic                        req_enc_b = 1'b0;
   logic [VEB_SAMPLE_W-1:0]     req_balance_sample = '0;
   logic [VEB_LEVELS_W-1:0]     req_button_levels = '0;
   logic                        req_power_pin = 1'b1;
   logic                        req_clear_pending = 1'b0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [VEB_VOL_W-1:0]        rsp_volume_position;
   logic signed [VEB_BAL_W-1:0] rsp_balance_half_db;
   logic                        rsp_update_pending;
   logic                        rsp_save_strobe;
   logic                        rsp_power_released;
   logic [VEB_CMD_W-1:0]        rsp_button_command;

   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [VEB_ADDR_W-1:0]       paddr = '0;
   logic [VEB_DATA_W-1:0]       pwdata = '0;
   logic [VEB_DATA_W-1:0]       prdata;
   logic                        pready;

   int fail_count, pending_results, results_checked, strobes_seen;
   int ticks_sent, settings_used, quiet_cycles;

   // stimulus scene, kept across phases
   logic [1:0] enc_pos;
   int         hold_left, scene_left, steady_left;
   int         sample_base;
   logic [3:0] level_scene;
   logic       power_scene;

   always #CLK_HALF clock = ~clock;

   volume_encoder_balance_tick DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_enc_a, .req_enc_b, .req_balance_sample,
      .req_button_levels, .req_power_pin, .req_clear_pending,
      .rsp_valid, .rsp_stall, .rsp_volume_position, .rsp_balance_half_db,
      .rsp_update_pending, .rsp_save_strobe, .rsp_power_released, .rsp_button_command,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   volume_encoder_balance_checker panel_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_enc_a, .req_enc_b, .req_balance_sample,
      .req_button_levels, .req_power_pin, .req_clear_pending,
      .rsp_valid, .rsp_stall, .rsp_volume_position, .rsp_balance_half_db,
      .rsp_update_pending, .rsp_save_strobe, .rsp_power_released, .rsp_button_command,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending_results, .results_checked, .strobes_seen
   );

   task automatic send_tick(input logic ea, input logic eb,
                            input logic [VEB_SAMPLE_W-1:0] smp,
                            input logic [VEB_LEVELS_W-1:0] lvl,
                            input logic pwr, input logic clr);
      @(negedge clock);
      req_valid          <= 1'b1;
      req_enc_a          <= ea;
      req_enc_b          <= eb;
      req_balance_sample <= smp;
      req_button_levels  <= lvl;
      req_power_pin      <= pwr;
      req_clear_pending  <= clr;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ticks_sent++;
   endtask

   task automatic write_reg(input veb_reg_type idx, input logic [VEB_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // drop valid and wait until every predicted result has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_phase(input int ticks, input int cw_pct,
                            input logic [VEB_VOL_W-1:0] vmax,
                            input logic [VEB_DELAY_W-1:0] delay,
                            input logic [VEB_SUM_W-1:0] thr);
      int         pick, gap, smp;
      logic       ea, eb;
      logic [3:0] lvl;
      settle();
      write_reg(VEB_REG_VOLUME_MAX, VEB_DATA_W'(vmax));
      write_reg(VEB_REG_SAVE_DELAY, VEB_DATA_W'(delay));
      write_reg(VEB_REG_THRESHOLD, VEB_DATA_W'(thr));
      settings_used++;
      for (int k = 0; k < ticks; k++) begin
         // encoder: mostly clean detents, some jumps of two and short holds
         if (hold_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               enc_pos = ($urandom_range(0, 99) < cw_pct) ? enc_pos + 2'd1 : enc_pos - 2'd1;
            else if (pick < 90)
               enc_pos = enc_pos + 2'd2;
            hold_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7)
                                                   : $urandom_range(8, 14);
         end
         hold_left--;
         ea = (enc_pos == 2'd1) || (enc_pos == 2'd2);
         eb = enc_pos[1];
         if ($urandom_range(0, 24) == 0)
            ea = ~ea;

         // slowly varying buttons and balance knob
         if (scene_left == 0) begin
            case ($urandom_range(0, 3))
               0: level_scene = 4'd0;
               1: level_scene = 4'd1 << $urandom_range(0, 3);
               2: level_scene = 4'hf;
               default: level_scene = 4'($urandom_range(0, 15));
            endcase
            power_scene = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 3))
               0: sample_base = 0;
               1: sample_base = 1023;
               default: sample_base = $urandom_range(0, 1023);
            endcase
            scene_left = $urandom_range(60, 250);
         end
         scene_left--;
         lvl = level_scene;
         if ($urandom_range(0, 29) == 0)
            lvl[$urandom_range(0, 3)] = ~lvl[$urandom_range(0, 3)];
         if ($urandom_range(0, 7) == 0)
            smp = $urandom_range(0, 1023);
         else
            smp = sample_base + $urandom_range(0, 30) - 15;
         if (smp < 0)
            smp = 0;
         if (smp > 1023)
            smp = 1023;

         send_tick(ea, eb, VEB_SAMPLE_W'(smp), lvl,
                   power_scene ^ ($urandom_range(0, 39) == 0),
                   $urandom_range(0, 9) == 0);

         // idle gaps, with occasional stretches of back-to-back items
         gap = 0;
         if (steady_left > 0) begin
            steady_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
               steady_left = $urandom_range(20, 60);
            else if (pick < 60)
               gap = 0;
            else if (pick < 92)
               gap = $urandom_range(1, 3);
            else
               gap = $urandom_range(8, 30);
         end
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // result-side stalls: free runs, short stalls and a few long ones
   initial begin
      int   run_left;
      logic level;
      run_left = 0;
      level    = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else begin
            case ($urandom_range(0, 99)) inside
               [0:54]:  begin level = 1'b0; run_left = $urandom_range(0, 20); end
               [55:91]: begin level = 1'b1; run_left = $urandom_range(0, 2);  end
               default: begin level = 1'b1; run_left = $urandom_range(9, 29); end
            endcase
            rsp_stall <= level;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      enc_pos     = 2'd0;
      hold_left   = 0;
      scene_left  = 0;
      steady_left = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, all encoder line pairs, each button alone
      for (int i = 0; i < 20; i++) begin
         send_tick(i[0], i[1],
                   (i % 3 == 0) ? 10'd0 : (i % 3 == 1) ? 10'd1023
                                                      : VEB_SAMPLE_W'($urandom_range(0, 1023)),
                   (i < 4) ? 4'd1 << i : (i[0] ? 4'hf : 4'h0),
                   i[2], i[3]);
      end

      run_phase(110, 50, 8'd1, 16'd1, 18'd0);
      run_phase(130, 85, 8'd255, 16'hffff, 18'h3ffff);
      run_phase(150, 85, 8'd20, 16'($urandom_range(2, 12)), 18'($urandom_range(0, 2000)));
      // cap below the current position: clockwise ignored, anticlockwise still counts
      run_phase(110, 60, 8'd3, 16'($urandom_range(1, 40)), 18'($urandom_range(100, 5000)));
      run_phase(100, $urandom_range(20, 80), 8'($urandom_range(1, 255)),
                16'($urandom_range(1, 200)), 18'($urandom_range(0, 4000)));
      run_phase(100, $urandom_range(20, 80), 8'($urandom_range(1, 255)),
                16'($urandom_range(1, 65535)), 18'($urandom_range(0, 262143)));

      settle();
      repeat (4) @(posedge clock);
      $display("Ran %0d ticks across %0d register settings plus defaults",
               ticks_sent, settings_used);
      $display("Checked %0d results, %0d of them with a save strobe",
               results_checked, strobes_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
